FILE: rtl/core/smsd_pkg.sv
// ----------------------------------------------------------------------------
// Sliding median spike detector package
// Shared constants, command and status types for the controller and datapath.
// ----------------------------------------------------------------------------
package smsd_pkg;

  localparam int WINDOW_MAX = 256;
  localparam int VALUE_BITS = 8;
  localparam int BIN_COUNT  = 1 << VALUE_BITS;
  localparam int PTR_BITS   = $clog2(WINDOW_MAX);
  localparam int LEN_BITS   = 9;
  localparam int HCNT_BITS  = $clog2(WINDOW_MAX + 1);
  localparam int SEEN_BITS  = HCNT_BITS + 1;
  localparam int TM_BITS    = 9;
  localparam int NCNT_BITS  = 32;

  typedef enum logic [1:0] {
    RSEL_BIN,
    RSEL_OLD,
    RSEL_NEW
  } hist_rsel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_OLD_RD,
    ST_DEC,
    ST_INC_RD,
    ST_INC_WR
  } ctrl_state_e;

  typedef struct packed {
    logic       start;
    logic       walk;
    hist_rsel_e rsel;
    logic       dec_wr;
    logic       commit;
  } smsd_cmd_t;

  typedef struct packed {
    logic full;
    logic walk_done;
    logic out_free;
  } smsd_sts_t;

endpackage

FILE: rtl/core/smsd_if.sv
// ----------------------------------------------------------------------------
// Sliding median spike detector channel interfaces
// Valid/ready channels for the sample word and the result word.
// ----------------------------------------------------------------------------
interface smsd_in_if import smsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface smsd_out_if import smsd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 window_full;
  logic                 notify;
  logic [TM_BITS-1:0]   twice_median;
  logic [NCNT_BITS-1:0] notify_count;

  modport source (output valid, output window_full, output notify, output twice_median,
                  output notify_count, input ready);
  modport sink (input valid, input window_full, input notify, input twice_median,
                input notify_count, output ready);
endinterface

FILE: rtl/core/sliding_median_spike_detector.sv
// ----------------------------------------------------------------------------
// Sliding median spike detector
// Flags samples at or above twice the median of the trailing window.
// ----------------------------------------------------------------------------
// Samples arrive as words on in_i and every sample yields exactly one result
// word on out_o, in order. Writing cfg_wdata_i with cfg_we_i sets the window
// length (0 acts as 1, values above 256 act as 256) and empties the window;
// the notification count is kept. Write it only while the block is idle.
// A sample that arrives while the window is still filling is stored without
// a walk. Once the window is full, the controller first walks the 256-bin
// histogram through its single read port, one bin per cycle, until it
// reaches the bin of the upper middle value m.
// in_i.ready is high only while the controller is idle, so a new sample can
// be taken in the cycle after the previous result is loaded into the output
// register, and not before.
// The output register holds a result while out_o.ready is low and
// the next sample proceeds up to its final update step, where it waits.
// Reset empties the window, clears the count and sets the window length to 1.
// ----------------------------------------------------------------------------
module sliding_median_spike_detector import smsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [LEN_BITS-1:0] cfg_wdata_i,
  smsd_in_if.sink             in_i,
  smsd_out_if.source          out_o
);

  smsd_cmd_t cmd;
  smsd_sts_t sts;

  smsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smsd_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_value_i         (in_i.value),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .out_window_full_o  (out_o.window_full),
    .out_notify_o       (out_o.notify),
    .out_twice_median_o (out_o.twice_median),
    .out_notify_count_o (out_o.notify_count)
  );

endmodule

FILE: rtl/core/smsd_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding median spike detector controller
// Sequences the histogram walk, the bin updates and the result commit.
// ----------------------------------------------------------------------------
module smsd_ctrl import smsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  smsd_sts_t sts_i,
  output smsd_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.rsel    = RSEL_NEW;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.full ? ST_WALK : ST_INC_RD;
        end
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        cmd_o.rsel = RSEL_BIN;
        if (sts_i.walk_done) begin
          state_d = ST_OLD_RD;
        end
      end
      ST_OLD_RD: begin
        cmd_o.rsel = RSEL_OLD;
        state_d    = ST_DEC;
      end
      ST_DEC: begin
        cmd_o.rsel   = RSEL_OLD;
        cmd_o.dec_wr = 1'b1;
        state_d      = ST_INC_RD;
      end
      ST_INC_RD: begin
        state_d = ST_INC_WR;
      end
      ST_INC_WR: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/smsd_dp.sv
// ----------------------------------------------------------------------------
// Sliding median spike detector datapath
// Sample ring, value histogram, median walk and the output register.
// ----------------------------------------------------------------------------
module smsd_dp import smsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LEN_BITS-1:0]   cfg_wdata_i,
  input  logic [VALUE_BITS-1:0] in_value_i,
  input  smsd_cmd_t             cmd_i,
  output smsd_sts_t             sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  out_window_full_o,
  output logic                  out_notify_o,
  output logic [TM_BITS-1:0]    out_twice_median_o,
  output logic [NCNT_BITS-1:0]  out_notify_count_o
);

  logic [LEN_BITS-1:0]   wl_q;
  logic [LEN_BITS-1:0]   len;
  logic [PTR_BITS-1:0]   ptr_q, ptr_d;
  logic [LEN_BITS-1:0]   ptr_inc;
  logic [LEN_BITS-1:0]   fill_q;
  logic [NCNT_BITS-1:0]  ncnt_q;
  logic [VALUE_BITS-1:0] sample_q;
  logic                  full_q;

  logic [VALUE_BITS-1:0] rmem [WINDOW_MAX];
  logic [VALUE_BITS-1:0] rdout_q;

  logic [HCNT_BITS-1:0]  hmem [BIN_COUNT];
  logic [BIN_COUNT-1:0]  hvalid_q;
  logic [HCNT_BITS-1:0]  hdout_q;
  logic                  hvld_q;
  logic [HCNT_BITS-1:0]  hcnt;
  logic [VALUE_BITS-1:0] hraddr;
  logic                  hwe;
  logic [VALUE_BITS-1:0] hwaddr;
  logic [HCNT_BITS-1:0]  hwdata;

  logic [VALUE_BITS-1:0] bin_q;
  logic [VALUE_BITS-1:0] pbin_q;
  logic                  pv_q;
  logic [SEEN_BITS-1:0]  seen_q;
  logic [SEEN_BITS-1:0]  seen_new;
  logic                  lo_found_q, hi_found_q;
  logic [VALUE_BITS-1:0] lo_q, hi_q;
  logic [PTR_BITS-1:0]   r_lo, r_hi;
  logic                  last_bin;
  logic                  lo_hit, hi_hit;

  logic [TM_BITS-1:0]    tm;
  logic                  hit;
  logic                  out_valid_q;
  logic                  out_free;

  always_comb begin
    if (wl_q == '0) begin
      len = LEN_BITS'(1);
    end else if (wl_q > LEN_BITS'(WINDOW_MAX)) begin
      len = LEN_BITS'(WINDOW_MAX);
    end else begin
      len = wl_q;
    end
  end

  assign r_lo     = PTR_BITS'((len - LEN_BITS'(1)) >> 1);
  assign r_hi     = PTR_BITS'(len >> 1);
  assign hcnt     = hvld_q ? hdout_q : '0;
  assign seen_new = seen_q + SEEN_BITS'(hcnt);
  assign last_bin = (pbin_q == VALUE_BITS'(BIN_COUNT - 1));
  assign lo_hit   = pv_q && !lo_found_q && ((seen_new > SEEN_BITS'(r_lo)) || last_bin);
  assign hi_hit   = pv_q && !hi_found_q && ((seen_new > SEEN_BITS'(r_hi)) || last_bin);

  assign tm       = full_q ? (TM_BITS'(lo_q) + TM_BITS'(hi_q)) : '0;
  assign hit      = full_q && (TM_BITS'(sample_q) >= tm);
  assign out_free = !out_valid_q || out_ready_i;
  assign ptr_inc  = LEN_BITS'(ptr_q) + LEN_BITS'(1);
  assign ptr_d    = (ptr_inc >= len) ? '0 : PTR_BITS'(ptr_inc);

  assign sts_o.full      = (fill_q >= len);
  assign sts_o.walk_done = cmd_i.walk && hi_hit;
  assign sts_o.out_free  = out_free;

  always_comb begin
    case (cmd_i.rsel)
      RSEL_BIN: hraddr = bin_q;
      RSEL_OLD: hraddr = rdout_q;
      RSEL_NEW: hraddr = sample_q;
      default:  hraddr = sample_q;
    endcase
  end

  always_comb begin
    hwe    = 1'b0;
    hwaddr = sample_q;
    hwdata = hcnt + HCNT_BITS'(1);
    if (cmd_i.dec_wr) begin
      hwe    = 1'b1;
      hwaddr = rdout_q;
      hwdata = (hcnt != '0) ? (hcnt - HCNT_BITS'(1)) : hcnt;
    end else if (cmd_i.commit) begin
      hwe = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hwe) begin
      hmem[hwaddr] <= hwdata;
    end
    hdout_q <= hmem[hraddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rmem[ptr_q] <= sample_q;
    end
    rdout_q <= rmem[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= '0;
      hvld_q   <= 1'b0;
    end else begin
      hvld_q <= hvalid_q[hraddr];
      if (cfg_we_i) begin
        hvalid_q <= '0;
      end else if (hwe) begin
        hvalid_q[hwaddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= LEN_BITS'(1);
      ptr_q  <= '0;
      fill_q <= '0;
      ncnt_q <= '0;
    end else if (cfg_we_i) begin
      wl_q   <= cfg_wdata_i;
      ptr_q  <= '0;
      fill_q <= '0;
    end else if (cmd_i.commit) begin
      ptr_q <= ptr_d;
      if (!full_q) begin
        fill_q <= fill_q + LEN_BITS'(1);
      end
      if (hit && (ncnt_q != '1)) begin
        ncnt_q <= ncnt_q + NCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q       <= 1'b0;
      lo_found_q <= 1'b0;
      hi_found_q <= 1'b0;
      full_q     <= 1'b0;
    end else if (cmd_i.start) begin
      pv_q       <= 1'b0;
      lo_found_q <= 1'b0;
      hi_found_q <= 1'b0;
      full_q     <= sts_o.full;
    end else if (cmd_i.walk) begin
      pv_q <= 1'b1;
      if (lo_hit) begin
        lo_found_q <= 1'b1;
      end
      if (hi_hit) begin
        hi_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sample_q <= in_value_i;
      bin_q    <= '0;
      seen_q   <= '0;
    end else if (cmd_i.walk) begin
      bin_q  <= bin_q + VALUE_BITS'(1);
      pbin_q <= bin_q;
      if (pv_q) begin
        seen_q <= seen_new;
      end
      if (lo_hit) begin
        lo_q <= pbin_q;
      end
      if (hi_hit) begin
        hi_q <= pbin_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_window_full_o  <= full_q;
      out_notify_o       <= hit;
      out_twice_median_o <= tm;
      out_notify_count_o <= (hit && (ncnt_q != '1)) ? (ncnt_q + NCNT_BITS'(1)) : ncnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len)
    else $error("fill level exceeds window length");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_BITS'(ptr_q) < len)
    else $error("ring pointer outside window");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> out_free)
    else $error("result overwritten before it was taken");

  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncnt_q >= $past(ncnt_q))
    else $error("notification count decreased");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.walk && hi_found_q) |-> lo_found_q)
    else $error("upper middle found before lower middle");
`endif

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Sliding median spike detector testbench
// Drives sample words through randomly idling valid/ready channels, predicts
// each result word from a private model of the window and its histogram, and
// compares every field of every result word in order.
// ----------------------------------------------------------------------------
module tb import smsd_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RANDOM_SAMPLES = 1000;

  typedef struct packed {
    logic                 window_full;
    logic                 notify;
    logic [TM_BITS-1:0]   twice_median;
    logic [NCNT_BITS-1:0] notify_count;
  } spike_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [LEN_BITS-1:0] cfg_wdata = '0;

  smsd_in_if  sample_if ();
  smsd_out_if result_if ();

  sliding_median_spike_detector i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (sample_if),
    .out_o      (result_if)
  );

  logic [VALUE_BITS-1:0] window_ring [WINDOW_MAX];
  int unsigned           bin_count [BIN_COUNT];
  int unsigned           write_slot;
  int unsigned           held_samples;
  logic [NCNT_BITS-1:0]  alert_total;
  logic [LEN_BITS-1:0]   window_reg;

  spike_word_t pending_spikes [$];
  bit          quiet = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned samples_sent = 0;
  int unsigned words_checked = 0;
  int unsigned notify_seen = 0;
  int unsigned window_writes = 0;

  always #4 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned active_length(logic [LEN_BITS-1:0] len);
    if (len == 0) return 1;
    if (len > WINDOW_MAX) return WINDOW_MAX;
    return len;
  endfunction

  function automatic void clear_window();
    foreach (bin_count[i]) bin_count[i] = 0;
    write_slot   = 0;
    held_samples = 0;
  endfunction

  // Returns the sample value at zero-based rank r of the sorted window.
  function automatic int unsigned ranked_sample(int unsigned r);
    int unsigned seen;
    seen = 0;
    for (int unsigned b = 0; b < BIN_COUNT; b++) begin
      seen += bin_count[b];
      if (seen > r) return b;
    end
    return BIN_COUNT - 1;
  endfunction

  function automatic spike_word_t predict_spike(logic [VALUE_BITS-1:0] v);
    spike_word_t res;
    int unsigned len;
    int unsigned slot;
    int unsigned tm;
    len  = active_length(window_reg);
    slot = write_slot % len;
    res  = '0;
    if (held_samples >= len) begin
      if (len % 2 == 1) tm = 2 * ranked_sample(len / 2);
      else tm = ranked_sample(len / 2 - 1) + ranked_sample(len / 2);
      res.window_full  = 1'b1;
      res.twice_median = tm[TM_BITS-1:0];
      if (v >= tm) begin
        res.notify = 1'b1;
        if (alert_total != '1) alert_total++;
      end
      if (bin_count[window_ring[slot]] != 0) bin_count[window_ring[slot]]--;
    end else begin
      held_samples++;
    end
    window_ring[slot] = v;
    bin_count[v]++;
    write_slot = (slot + 1) % len;
    res.notify_count = alert_total;
    return res;
  endfunction

  function automatic logic [VALUE_BITS-1:0] draw_sample(int unsigned level);
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 99);
    if (r < 8) v = $urandom_range(0, BIN_COUNT - 1);
    else if (r < 14) v = (level == 0) ? $urandom_range(0, 1) : 2 * level - 1 + $urandom_range(0, 2);
    else if (r < 20) v = 2 * level + $urandom_range(0, 80);
    else v = $urandom_range(level / 2, level + level / 2);
    if (v > BIN_COUNT - 1) v = BIN_COUNT - 1;
    return v[VALUE_BITS-1:0];
  endfunction

  task automatic send_sample(input logic [VALUE_BITS-1:0] v);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.value <= v;
    do @(posedge clk); while (!sample_if.ready);
    pending_spikes.push_back(predict_spike(v));
    samples_sent++;
  endtask

  // The block must be idle with every result word collected before a write.
  task automatic set_window_length(input logic [LEN_BITS-1:0] len);
    sample_if.valid <= 1'b0;
    while (pending_spikes.size() != 0 || !sample_if.ready) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we     <= 1'b0;
    window_reg = len;
    clear_window();
    window_writes++;
  endtask

  task automatic run_phase(input logic [LEN_BITS-1:0] len, input int unsigned count,
                           input int unsigned level);
    set_window_length(len);
    repeat (count) send_sample(draw_sample(level));
  endtask

  task automatic test_directed_windows();
    send_sample(8'd10);  send_sample(8'd20);  send_sample(8'd9);
    send_sample(8'd18);  send_sample(8'd0);   send_sample(8'd0);
    send_sample(8'd255); send_sample(8'd128); send_sample(8'd255);
    set_window_length(9'd2);
    send_sample(8'd4);   send_sample(8'd6);   send_sample(8'd10);
    send_sample(8'd9);   send_sample(8'd19);
    set_window_length(9'd0);
    send_sample(8'd255); send_sample(8'd255); send_sample(8'd1);
    set_window_length(9'd3);
    send_sample(8'd1);   send_sample(8'd200); send_sample(8'd3);
    send_sample(8'd7);   send_sample(8'd0);
  endtask

  task automatic test_random_windows();
    int unsigned start_cnt;
    int unsigned r;
    logic [LEN_BITS-1:0] len;
    start_cnt = samples_sent;
    while (samples_sent - start_cnt < RANDOM_SAMPLES) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = LEN_BITS'($urandom_range(1, 12));
      else if (r < 90) len = LEN_BITS'($urandom_range(13, 64));
      else len = LEN_BITS'($urandom_range(65, 200));
      run_phase(len, active_length(len) + $urandom_range(10, 40),
                ($urandom_range(0, 99) < 85) ? $urandom_range(0, 100) : $urandom_range(100, 200));
    end
  endtask

  task automatic test_window_extremes();
    run_phase(9'd256, WINDOW_MAX + 40, $urandom_range(0, 50));
    run_phase(9'd511, WINDOW_MAX + 30, $urandom_range(0, 50));
    run_phase(9'd257, WINDOW_MAX + 30, $urandom_range(0, 50));
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    run_phase(9'd4, 60, $urandom_range(0, 120));
    run_phase(9'd7, 60, $urandom_range(0, 120));
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) begin
      if (pending_spikes.size() == 0) begin
        $error("result word with no sample pending");
        error_cnt++;
      end else begin
        if (result_if.window_full !== pending_spikes[0].window_full) begin
          $error("window_full: expected %0d, got %0d",
                 pending_spikes[0].window_full, result_if.window_full);
          error_cnt++;
        end
        if (result_if.notify !== pending_spikes[0].notify) begin
          $error("notify: expected %0d, got %0d", pending_spikes[0].notify, result_if.notify);
          error_cnt++;
        end
        if (result_if.twice_median !== pending_spikes[0].twice_median) begin
          $error("twice_median: expected %0d, got %0d",
                 pending_spikes[0].twice_median, result_if.twice_median);
          error_cnt++;
        end
        if (result_if.notify_count !== pending_spikes[0].notify_count) begin
          $error("notify_count: expected %0d, got %0d",
                 pending_spikes[0].notify_count, result_if.notify_count);
          error_cnt++;
        end
        if (pending_spikes[0].notify) notify_seen++;
        void'(pending_spikes.pop_front());
        words_checked++;
      end
    end
    if (hold_cycles != 0) begin
      result_if.ready <= 1'b0;
      hold_cycles--;
    end else begin
      result_if.ready <= 1'b1;
      hold_cycles = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    sample_if.valid = 1'b0;
    sample_if.value = '0;
    window_reg      = 9'd1;
    alert_total     = '0;
    foreach (window_ring[i]) window_ring[i] = '0;
    clear_window();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_windows();
    test_random_windows();
    test_window_extremes();
    test_back_to_back();

    sample_if.valid <= 1'b0;
    while (pending_spikes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("tb: %0d samples sent over %0d window length writes", samples_sent, window_writes);
    $display("tb: %0d result words checked, %0d of them notifications", words_checked,
             notify_seen);
    if (error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/smsd_pkg.sv
rtl/core/smsd_if.sv
rtl/core/smsd_ctrl.sv
rtl/core/smsd_dp.sv
rtl/core/sliding_median_spike_detector.sv
verif/tb.sv
